FILE: src/fbd_pkg.sv
// shared constants and types for the frame baseline delta-f-over-f block
`timescale 1ns / 1ps
package fbd_pkg;

    localparam int HISTORY_FRAMES = 8;
    localparam int FRAME_PIXELS   = 262144;

    localparam int TIME_W = 40;
    localparam int IDX_W  = 18;
    localparam int PIX_W  = 8;
    localparam int INTV_W = 16;

    localparam int SLOT_W     = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
    localparam int PIX_AW     = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int HIST_DEPTH = HISTORY_FRAMES * FRAME_PIXELS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int SUM_MAX   = HISTORY_FRAMES * 255;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int DEN_W     = SUM_W + 1;
    localparam int DIV_W     = DEN_W + PIX_W;
    localparam int NUM_W     = DIV_W + 1;
    localparam int P_MUL     = 510 * HISTORY_FRAMES;
    localparam int DIV_STEPS = PIX_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = 2;
    localparam int OUT_DEPTH   = 16;
    localparam int OUT_AW      = 4;
    localparam int CNT_W       = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd1;
    localparam logic [INTV_W-1:0]    INTERVAL_RESET = 16'd100;

    typedef struct packed {
        logic [PIX_AW-1:0]  idx;
        logic               in_frame;
        logic [PIX_W-1:0]   pixel;
        logic               upd;
        logic               full;
        logic [HIST_AW-1:0] pos;
    } front_item_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic [SUM_W-1:0] sum;
    } back_res_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic             zero;
        logic             nonpos;
        logic             sat;
        logic [DIV_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [PIX_W-1:0] quo;
    } div_stage_t;

    typedef struct packed {
        logic             push;
        logic [CNT_W-1:0] cnt;
    } out_stat_t;

endpackage

FILE: src/fbd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

FILE: src/fbd_front.sv
// front end: takes pixels, decides baseline update at frame start, tags history slot
`timescale 1ns / 1ps
module fbd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [fbd_pkg::TIME_W-1:0] frame_time,
    input  logic [fbd_pkg::IDX_W-1:0]  pixel_index,
    input  logic [fbd_pkg::PIX_W-1:0]  pixel_value,
    input  logic [fbd_pkg::INTV_W-1:0] interval,
    input  logic                       clear_busy,
    input  logic                       queue_full,
    output logic                       push,
    output fbd_pkg::front_item_t       item
);
    import fbd_pkg::*;

    logic              updates_reg, updates_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              full_reg, full_next;
    logic              upd_now, in_frame, last_pix, due;

    assign in_ready = !clear_busy && !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        in_frame = 32'(pixel_index) < 32'(FRAME_PIXELS);
        last_pix = 32'(pixel_index) == 32'(FRAME_PIXELS - 1);
        due      = {1'b0, frame_time} > ({1'b0, last_reg} + (TIME_W+1)'(interval));
        upd_now  = (pixel_index == '0) ? due : updates_reg;

        item.idx      = PIX_AW'(pixel_index);
        item.in_frame = in_frame;
        item.pixel    = pixel_value;
        item.upd      = upd_now && in_frame;
        item.full     = full_reg;
        item.pos      = HIST_AW'(slot_reg) * HIST_AW'(FRAME_PIXELS) + HIST_AW'(pixel_index);

        updates_next = updates_reg;
        last_next    = last_reg;
        slot_next    = slot_reg;
        full_next    = full_reg;
        if (push)
        begin
            if (pixel_index == '0)
            begin
                updates_next = due;
                if (due)
                begin
                    last_next = frame_time;
                end
            end
            if (upd_now && in_frame && last_pix)
            begin
                if (slot_reg == SLOT_W'(HISTORY_FRAMES - 1))
                begin
                    slot_next = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            updates_reg <= 1'b0;
            last_reg    <= '0;
            slot_reg    <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            updates_reg <= updates_next;
            last_reg    <= last_next;
            slot_reg    <= slot_next;
            full_reg    <= full_next;
        end
    end
endmodule

FILE: src/fbd_queue.sv
// short queue of classified pixels between front and back
`timescale 1ns / 1ps
module fbd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fbd_pkg::front_item_t din,
    input  logic                 pop,
    output fbd_pkg::front_item_t head,
    output logic                 full,
    output logic                 empty
);
    import fbd_pkg::*;

    front_item_t     mem_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (Q_AW+1)'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: src/fbd_back.sv
// back end: running sum and history memories, sum update, clearing pass
`timescale 1ns / 1ps
module fbd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fbd_pkg::front_item_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 clear_busy,
    input  fbd_pkg::out_stat_t   ostat,
    output fbd_pkg::back_res_t   res
);
    import fbd_pkg::*;

    logic              clr_busy_reg, clr_busy_next;
    logic [PIX_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  inflight_reg, inflight_next;
    logic              s1_valid_reg;
    front_item_t       s1_reg;
    back_res_t         res_reg, res_next;

    logic               fwd_valid_reg, fwd_valid_next;
    logic [PIX_AW-1:0]  fwd_idx_reg;
    logic [HIST_AW-1:0] fwd_pos_reg;
    logic [SUM_W-1:0]   fwd_sum_reg;
    logic [PIX_W-1:0]   fwd_pix_reg;

    logic [SUM_W-1:0]   sum_rdata, sum_old, sum_new, sum_wdata;
    logic [PIX_W-1:0]   hist_rdata, hist_old;
    logic [PIX_AW-1:0]  sum_waddr;
    logic               sum_we, hist_we, wr_upd;
    logic signed [SUM_W+2:0] s_calc;

    assign clear_busy = clr_busy_reg;
    assign res        = res_reg;
    // issue only with a free output slot reserved for every item in flight
    assign pop = !empty && !clr_busy_reg &&
                 ((CNT_W+1)'(inflight_reg) + (CNT_W+1)'(ostat.cnt) < (CNT_W+1)'(OUT_DEPTH));

    fbd_ram #(.WIDTH(SUM_W), .DEPTH(FRAME_PIXELS)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (head.idx),
        .rdata (sum_rdata)
    );

    fbd_ram #(.WIDTH(PIX_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (s1_reg.pos),
        .wdata (s1_reg.pixel),
        .raddr (head.pos),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        // the previous write lands in the same edge that registered our read
        sum_old  = (fwd_valid_reg && fwd_idx_reg == s1_reg.idx) ? fwd_sum_reg : sum_rdata;
        hist_old = (fwd_valid_reg && fwd_pos_reg == s1_reg.pos) ? fwd_pix_reg : hist_rdata;
        s_calc   = (SUM_W+3)'(sum_old) + (SUM_W+3)'(s1_reg.pixel);
        if (s1_reg.full)
        begin
            s_calc = s_calc - (SUM_W+3)'(hist_old);
        end
        if (s_calc < 0)
        begin
            sum_new = '0;
        end
        else if (s_calc > (SUM_W+3)'(SUM_MAX))
        begin
            sum_new = SUM_W'(SUM_MAX);
        end
        else
        begin
            sum_new = SUM_W'(s_calc);
        end

        wr_upd    = s1_valid_reg && s1_reg.upd;
        hist_we   = wr_upd;
        sum_we    = clr_busy_reg || wr_upd;
        sum_waddr = clr_busy_reg ? clr_cnt_reg : s1_reg.idx;
        sum_wdata = clr_busy_reg ? '0 : sum_new;

        res_next.valid = s1_valid_reg;
        res_next.pixel = s1_reg.pixel;
        if (!s1_reg.in_frame)
        begin
            res_next.sum = '0;
        end
        else
        begin
            res_next.sum = s1_reg.upd ? sum_new : sum_old;
        end

        fwd_valid_next = clr_busy_reg ? 1'b0 : (fwd_valid_reg || wr_upd);
        inflight_next  = inflight_reg + CNT_W'(pop) - CNT_W'(ostat.push);

        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == PIX_AW'(FRAME_PIXELS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= head;
        end
        if (wr_upd)
        begin
            fwd_idx_reg <= s1_reg.idx;
            fwd_pos_reg <= s1_reg.pos;
            fwd_sum_reg <= sum_new;
            fwd_pix_reg <= s1_reg.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            inflight_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            res_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            inflight_reg  <= inflight_next;
            s1_valid_reg  <= pop;
            res_reg       <= res_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end
endmodule

FILE: src/fbd_dff.sv
// ratio pipeline: one quotient bit per stage, rounding, output fifo
`timescale 1ns / 1ps
module fbd_dff (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fbd_pkg::back_res_t        res,
    input  logic                      mode,
    output fbd_pkg::out_stat_t        ostat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [fbd_pkg::PIX_W-1:0] display_value
);
    import fbd_pkg::*;

    div_stage_t st_reg  [DIV_STEPS+1];
    div_stage_t st_next [DIV_STEPS+1];

    logic [NUM_W-1:0]  prod_p, prod_s;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]  den;
    logic [DIV_W-1:0]  trial;
    logic [DIV_W:0]    twice_r;
    logic              round_up;
    logic [PIX_W-1:0]  ratio, result;

    logic [PIX_W-1:0]  fifo_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              push, pop;

    always_comb
    begin
        prod_p = NUM_W'(res.pixel) * NUM_W'(P_MUL);
        prod_s = NUM_W'(res.sum) * NUM_W'(255);
        num    = $signed(prod_p) - $signed(prod_s);
        den    = {res.sum, 1'b0};

        st_next[0].valid  = res.valid;
        st_next[0].pixel  = res.pixel;
        st_next[0].zero   = res.sum == '0;
        st_next[0].nonpos = num <= 0;
        st_next[0].sat    = num[DIV_W-1:0] >= {den, {PIX_W{1'b0}}};
        st_next[0].rem    = num[DIV_W-1:0];
        st_next[0].den    = den;
        st_next[0].quo    = '0;

        for (int i = 1; i <= DIV_STEPS; i++)
        begin
            st_next[i] = st_reg[i-1];
            trial = DIV_W'(st_reg[i-1].den) << (DIV_STEPS - i);
            if (st_reg[i-1].rem >= trial)
            begin
                st_next[i].rem = st_reg[i-1].rem - trial;
                st_next[i].quo[DIV_STEPS-i] = 1'b1;
            end
        end
    end

    // round half to even, then clamp to the display range
    always_comb
    begin
        twice_r  = {st_reg[DIV_STEPS].rem, 1'b0};
        round_up = (twice_r > (DIV_W+1)'(st_reg[DIV_STEPS].den)) ||
                   ((twice_r == (DIV_W+1)'(st_reg[DIV_STEPS].den)) && st_reg[DIV_STEPS].quo[0]);
        if (st_reg[DIV_STEPS].quo == '1)
        begin
            ratio = '1;
        end
        else
        begin
            ratio = st_reg[DIV_STEPS].quo + PIX_W'(round_up);
        end

        if (!mode)
        begin
            result = st_reg[DIV_STEPS].pixel;
        end
        else if (st_reg[DIV_STEPS].zero)
        begin
            result = (st_reg[DIV_STEPS].pixel != '0) ? '1 : '0;
        end
        else if (st_reg[DIV_STEPS].nonpos)
        begin
            result = '0;
        end
        else if (st_reg[DIV_STEPS].sat)
        begin
            result = '1;
        end
        else
        begin
            result = ratio;
        end

        push       = st_reg[DIV_STEPS].valid;
        pop        = out_valid && out_ready;
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next   = cnt_reg + CNT_W'(push) - CNT_W'(pop);
        ostat.push = push;
        ostat.cnt  = cnt_reg;
    end

    assign out_valid     = cnt_reg != '0;
    assign display_value = fifo_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                st_reg[i] <= '0;
            end
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: src/frame_baseline_dff.sv
// top level of the frame baseline delta-f-over-f block
`timescale 1ns / 1ps
// Takes one grayscale pixel per clock while in_ready is high, with its frame
// time, and returns one display value per pixel, in order. Mode 0 returns the
// raw pixel; mode 1 returns round(255*(pixel*8/sum) - 127.5) clamped to 0..255,
// where sum is the pixel's running total over the last 8 updating frames. A
// frame updates the baseline when its time (sampled at pixel 0) is above last
// update time plus the interval. Throughput is one transfer per cycle unless
// stalled, set by the single read and write port of the running sum and history
// memories; a pixel's result passes memory read, sum update, ratio setup, one
// quotient bit per stage over 8 stages and the output fifo. After reset the sum
// memory is cleared one entry per cycle with in_ready low; configuration writes
// are taken at any time but are meant to be made while the block is idle.
module frame_baseline_dff (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fbd_pkg::TIME_W-1:0]     frame_time,
    input  logic [fbd_pkg::IDX_W-1:0]      pixel_index,
    input  logic [fbd_pkg::PIX_W-1:0]      pixel_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fbd_pkg::PIX_W-1:0]      display_value,
    input  logic                           cfg_we,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbd_pkg::*;

    // configuration registers
    logic              mode_reg, mode_next;
    logic [INTV_W-1:0] interval_reg, interval_next;

    // front to queue to back
    front_item_t fr_item, q_head;
    logic        fr_push, q_full, q_empty, q_pop;
    logic        clear_busy;
    back_res_t   back_res;
    out_stat_t   ostat;

    always_comb
    begin
        mode_next     = mode_reg;
        interval_next = interval_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:     mode_next     = cfg_data[0];
                CFG_INTERVAL: interval_next = INTV_W'(cfg_data);
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            mode_reg     <= mode_next;
            interval_reg <= interval_next;
        end
    end

    // frame start decision and history slot tagging
    fbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_time  (frame_time),
        .pixel_index (pixel_index),
        .pixel_value (pixel_value),
        .interval    (interval_reg),
        .clear_busy  (clear_busy),
        .queue_full  (q_full),
        .push        (fr_push),
        .item        (fr_item)
    );

    // decouples intake from memory issue
    fbd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .din   (fr_item),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    // memories and running sum update, issue gated by output credit
    fbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .empty      (q_empty),
        .pop        (q_pop),
        .clear_busy (clear_busy),
        .ostat      (ostat),
        .res        (back_res)
    );

    // ratio, rounding and output buffering
    fbd_dff u_dff (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (back_res),
        .mode          (mode_reg),
        .ostat         (ostat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .display_value (display_value)
    );
endmodule

FILE: dv/frame_baseline_dff_test.sv
// self-checking testbench for the frame baseline delta-f-over-f block
`timescale 1ns / 1ps
module frame_baseline_dff_test;
    import fbd_pkg::*;

    localparam longint  T_MAX      = 64'hFF_FFFF_FFFF;
    localparam int      LAST_PIXEL = FRAME_PIXELS - 1;
    localparam int      IDLE_LIMIT = 400000;   // covers the sum memory clear after reset
    localparam int      DRAIN_WAIT = 30;       // margin beyond the pipeline latency
    localparam int      TOTAL_ITEMS = 950;

    // expected display values, kept by a bit-exact copy of the baseline state
    class baseline_scoreboard;
        bit               mode;
        bit [INTV_W-1:0]  interval;
        int               sums[int];
        int               history[int];
        int               slot;
        bit               full;
        longint           last_upd;
        bit               updating;
        logic [PIX_W-1:0] due[$];
        int               errors;

        function new();
            mode = 0;
            interval = INTERVAL_RESET;
            slot = 0;
            full = 0;
            last_upd = 0;
            updating = 0;
            errors = 0;
        endfunction

        function int hist_key(int s, int idx);
            return s * FRAME_PIXELS + idx;
        endfunction

        // true when this pixel would read back a history entry never written
        function bit reads_unwritten(longint t, int idx);
            bit u;
            u = (idx == 0) ? (t > last_upd + interval) : updating;
            return u && full && !history.exists(hist_key(slot, idx));
        endfunction

        // round(255*(p*N/sum) - 127.5), ties to even, clamped to a byte
        function logic [PIX_W-1:0] ratio(int p, int sum);
            longint num, den, q, r;
            if (sum == 0)
                return (p != 0) ? 8'd255 : 8'd0;
            num = 510 * longint'(p) * HISTORY_FRAMES - 255 * longint'(sum);
            if (num <= 0)
                return 8'd0;
            den = 2 * longint'(sum);
            q = num / den;
            r = num % den;
            if (2 * r > den || (2 * r == den && q[0]))
                q++;
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function void note_pixel(longint t, int idx, int p);
            int s;
            int key;
            if (idx == 0)
            begin
                updating = t > last_upd + interval;
                if (updating)
                    last_upd = t;
            end
            if (updating)
            begin
                key = hist_key(slot, idx);
                s = (sums.exists(idx) ? sums[idx] : 0) + p;
                if (full)
                    s -= history.exists(key) ? history[key] : 0;
                if (s < 0)
                    s = 0;
                if (s > SUM_MAX)
                    s = SUM_MAX;
                sums[idx] = s;
                history[key] = p;
                if (idx == LAST_PIXEL)
                begin
                    slot = (slot + 1) % HISTORY_FRAMES;
                    if (slot == 0)
                        full = 1;
                end
            end
            s = sums.exists(idx) ? sums[idx] : 0;
            due.push_back(mode ? ratio(p, s) : p[PIX_W-1:0]);
        endfunction

        function void check_value(logic [PIX_W-1:0] got);
            logic [PIX_W-1:0] want;
            if (due.size() == 0)
            begin
                $error("display_value: no result expected, got %0d", got);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got !== want)
            begin
                $error("display_value: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [TIME_W-1:0]     frame_time;
    logic [IDX_W-1:0]      pixel_index;
    logic [PIX_W-1:0]      pixel_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      display_value;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    baseline_scoreboard sb = new();
    bit quiet;          // no idling on either side while set
    bit long_hold;      // receiver holds off once for a long stretch
    int sent;
    int idle_cycles;

    frame_baseline_dff i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .frame_time    (frame_time),
        .pixel_index   (pixel_index),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .display_value (display_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // watchdog: any stretch without a transfer on either side ends the run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off so the block backs up
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            if (long_hold)
            begin
                stall = 300;
                long_hold = 0;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 6);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_value(display_value);
        end
    end

    // one pixel transfer; called right after the previous transfer's edge
    task automatic send_pixel(longint t, int idx, int p);
        int gap;
        if (sb.reads_unwritten(t, idx))
        begin
            // would read a history entry nobody wrote: a non-updating pixel 0 instead
            t = 0;
            idx = 0;
        end
        gap = quiet ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        frame_time  <= t[TIME_W-1:0];
        pixel_index <= idx[IDX_W-1:0];
        pixel_value <= p[PIX_W-1:0];
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(t, idx, p);
        sent++;
    endtask

    function automatic longint rand_time();
        return {$urandom, $urandom} & T_MAX;
    endfunction

    // a time that makes pixel 0 update the baseline, if one still exists
    function automatic longint update_time();
        longint base;
        base = sb.last_upd + sb.interval + 1;
        if (base > T_MAX)
            return rand_time();
        if ($urandom_range(0, 149) == 0)
            base += longint'($urandom) << 7;
        else
            base += $urandom_range(0, 20);
        return (base > T_MAX) ? T_MAX : base;
    endfunction

    // a time at or below last update plus interval: the frame keeps the baseline
    function automatic longint still_time();
        longint top;
        top = sb.last_upd + sb.interval;
        if (top > T_MAX)
            top = T_MAX;
        if ($urandom_range(0, 3) == 0)
            return top;
        return rand_time() % (top + 1);
    endfunction

    // well-formed frame: pixels 0..n-1 then the last pixel, which ends the frame
    task automatic send_frame(longint t);
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_pixel((i == 0) ? t : rand_time(), i, $urandom_range(0, 255));
        send_pixel(rand_time(), LAST_PIXEL, $urandom_range(0, 255));
    endtask

    // broken frame: repeated, skipped and scattered indices
    task automatic send_broken();
        int n;
        int idx;
        longint t;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: idx = 0;
                1: idx = $urandom_range(0, 4);
                2: idx = $urandom_range(0, LAST_PIXEL);
                default: idx = LAST_PIXEL;
            endcase
            if (i == 0)
                idx = 0;
            t = $urandom_range(0, 1) ? update_time() : still_time();
            send_pixel(t, idx, $urandom_range(0, 255));
        end
    endtask

    // registers change only with nothing in flight
    task automatic set_config(bit mode, int interval);
        // the last pixel stays offered after its transfer until withdrawn here
        @(negedge clk);
        in_valid <= 1'b0;
        wait (sb.due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(negedge clk);
        cfg_index <= CFG_INTERVAL;
        cfg_data  <= interval[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.mode     = mode;
        sb.interval = interval[INTV_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int budget;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        frame_time  = '0;
        pixel_index = '0;
        pixel_value = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_MODE;
        cfg_data    = '0;
        quiet       = 0;
        long_hold   = 0;
        sent        = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: dF/F with no interval, zero sums, extremes, time going back
        set_config(1, 0);
        send_pixel(0, 0, 0);                  // time zero never updates; zero sum, zero pixel
        send_pixel(T_MAX, 1, 255);            // zero sum, nonzero pixel
        send_pixel(0, LAST_PIXEL, 255);
        send_pixel(5, 0, 255);                // updating frame
        send_pixel(T_MAX, 1, 255);
        send_pixel(0, 2, 0);
        send_pixel(7, 3, 128);
        send_pixel(1, LAST_PIXEL, 255);
        send_pixel(3, 0, 1);                  // time went back: no update
        send_pixel(6, 0, 0);                  // updates again, pixel 0 against a nonzero sum
        send_pixel(6, 1, 0);
        send_pixel(6, 0, 255);                // repeated pixel 0 inside a frame
        send_pixel(6, LAST_PIXEL, 0);

        // random phases over several settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_config(0, 100);
                1: set_config(1, 65535);
                2: set_config(1, 0);
                3: set_config(0, $urandom_range(0, 65535));
                default: set_config(1, $urandom_range(1, 300));
            endcase
            budget = sent + (TOTAL_ITEMS - 13) / 5;
            quiet = (ph == 2);
            while (sent < budget)
            begin
                if (ph == 3 && sent > budget - 100 && sent < budget - 90)
                    long_hold = 1;
                kind = $urandom_range(0, 99);
                if (kind < 60)
                    send_frame(update_time());
                else if (kind < 75)
                    send_frame(still_time());
                else
                    send_broken();
            end
        end
        quiet = 0;
        // last frame pushes the time to its top; no update can follow
        send_frame(T_MAX);

        @(negedge clk);
        in_valid <= 1'b0;
        wait (sb.due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/fbd_pkg.sv
src/fbd_ram.sv
src/fbd_front.sv
src/fbd_queue.sv
src/fbd_back.sv
src/fbd_dff.sv
src/frame_baseline_dff.sv
dv/frame_baseline_dff_test.sv
